@@ sv/estg_pkg.sv @@
// Package with shared widths, codes, control structs and the sine table function.
`timescale 1ns / 1ps
package estg_pkg;

  localparam int FREQ_W     = 16;
  localparam int DUR_W      = 16;
  localparam int RATE_W     = 16;
  localparam int VOL_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int TOTAL_W    = 22;
  localparam int PHASE_W    = 32;
  localparam int SINE_W     = 15;
  localparam int ENV_W      = 17;
  localparam int GAIN_W     = 17;
  localparam int G30_W      = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd16000;
  localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd100;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;
  localparam int                AMPLITUDE  = 30000;
  localparam logic [RATE_W-1:0] MS_PER_S   = 16'd1000;

  localparam int RAMP_SAMPLES_DEF = 80;
  localparam int SINE_DEPTH_DEF   = 256;

  // Divider: 48-bit dividend, one quotient bit per cycle.
  localparam int DIV_DVD_W = FREQ_W + PHASE_W;
  localparam int DIV_STEPS = DIV_DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Gain = floor(vol * 2^16 / 100) as vol * ceil(2^40 / 100) >> 24, exact for vol <= 100.
  localparam int                GAIN_SHIFT = 24;
  localparam int                GAIN_RW    = 34;
  localparam logic [GAIN_RW-1:0] GAIN_RECIP =
    GAIN_RW'(((64'd1 << (16 + GAIN_SHIFT)) + 64'd99) / 64'd100);

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 1'b0,
    CFG_VOLUME      = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } tone_cmd_t;

  typedef struct packed {
    logic take_item;
    logic cnt_load;
    logic cnt_store;
    logic inc_load;
    logic start_done;
    logic tick_phase;
    logic tick_rom;
    logic tick_mul1;
    logic tick_mul2;
    logic tick_out;
  } estg_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic tone_active;
    logic out_busy;
  } estg_sts_t;

  // Quarter-wave sine entry in Q0.15 from an angle x in Q30, six Taylor terms.
  function automatic logic [SINE_W-1:0] sine_from_x(input logic [63:0] x);
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    t = x;
    s = x;
    t = (t * x) >> 30;
    t = (t * x) >> 30;
    t = t / 64'd6;
    s = (t > s) ? 64'd0 : s - t;
    t = (t * x) >> 30;
    t = (t * x) >> 30;
    t = t / 64'd20;
    s = s + t;
    t = (t * x) >> 30;
    t = (t * x) >> 30;
    t = t / 64'd42;
    s = (t > s) ? 64'd0 : s - t;
    t = (t * x) >> 30;
    t = (t * x) >> 30;
    t = t / 64'd72;
    s = s + t;
    t = (t * x) >> 30;
    t = (t * x) >> 30;
    t = t / 64'd110;
    s = (t > s) ? 64'd0 : s - t;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? SINE_W'(32767) : v[SINE_W-1:0];
  endfunction

endpackage

@@ sv/estg_req_if.sv @@
// Interface for the input channel: start and tick items.
`timescale 1ns / 1ps
interface estg_req_if;
  import estg_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [FREQ_W-1:0] freq_hz;
  logic [DUR_W-1:0]  tone_ms;
  modport source(output valid, output cmd, output freq_hz, output tone_ms, input ready);
  modport sink(input valid, input cmd, input freq_hz, input tone_ms, output ready);
endinterface

@@ sv/estg_smp_if.sv @@
// Interface for the output channel: PCM samples with an end-of-tone flag.
`timescale 1ns / 1ps
interface estg_smp_if;
  import estg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;
  modport source(output valid, output sample, output last_sample, input ready);
  modport sink(input valid, input sample, input last_sample, output ready);
endinterface

@@ sv/estg_cfg_if.sv @@
// Interface for the configuration write channel.
`timescale 1ns / 1ps
interface estg_cfg_if;
  import estg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/estg_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, keeps the low 32 quotient bits.
`timescale 1ns / 1ps
module estg_div import estg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [DIV_DVD_W-1:0] dividend,
  input  logic [RATE_W-1:0]    divisor,
  output logic                 busy,
  output logic [PHASE_W-1:0]   quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    rem;
  logic [DIV_DVD_W-1:0] dvd;
  logic [RATE_W-1:0]    dsr;
  logic [RATE_W:0]      trial;
  logic                 ge;
  logic [RATE_W:0]      diff;

  assign trial = {rem, dvd[DIV_DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      dvd      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      dvd      <= {dvd[DIV_DVD_W-2:0], 1'b0};
      quotient <= {quotient[PHASE_W-2:0], ge};
    end
  end

endmodule

@@ sv/estg_ctrl.sv @@
// Controller state machine sequencing start setup and per-tick sample computation.
`timescale 1ns / 1ps
module estg_ctrl import estg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  estg_sts_t sts,
  output estg_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE,
    CNT_LOAD,
    CNT_WAIT,
    INC_LOAD,
    INC_WAIT,
    T_PHASE,
    T_ROM,
    T_MUL1,
    T_MUL2,
    T_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (tone_cmd_t'(in_cmd) == CMD_START) begin
              state <= CNT_LOAD;
            end else if (sts.tone_active) begin
              state <= T_PHASE;
            end
          end
        end
        CNT_LOAD: state <= CNT_WAIT;
        CNT_WAIT: state <= INC_LOAD;
        INC_LOAD: state <= INC_WAIT;
        INC_WAIT: begin
          if (!sts.div_busy) begin
            state <= IDLE;
          end
        end
        T_PHASE: state <= T_ROM;
        T_ROM:   state <= T_MUL1;
        T_MUL1:  state <= T_MUL2;
        T_MUL2:  state <= T_OUT;
        T_OUT: begin
          if (!sts.out_busy) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.take_item  = accept;
    cmd.cnt_load   = (state == CNT_LOAD);
    cmd.cnt_store  = (state == CNT_WAIT);
    cmd.inc_load   = (state == INC_LOAD);
    cmd.start_done = (state == INC_WAIT) && !sts.div_busy;
    cmd.tick_phase = (state == T_PHASE);
    cmd.tick_rom   = (state == T_ROM);
    cmd.tick_mul1  = (state == T_MUL1);
    cmd.tick_mul2  = (state == T_MUL2);
    cmd.tick_out   = (state == T_OUT) && !sts.out_busy;
  end

endmodule

@@ sv/estg_dp.sv @@
// Datapath: configuration, tone state, divider, sine table, envelope and gain multipliers.
`timescale 1ns / 1ps
module estg_dp import estg_pkg::*; #(
  parameter int RAMP_SAMPLES     = RAMP_SAMPLES_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  estg_cmd_t                  cmd,
  output estg_sts_t                  sts,
  input  logic [FREQ_W-1:0]          in_freq,
  input  logic [DUR_W-1:0]           in_dur,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last
);

  localparam int POS_W   = $clog2(4 * SINE_TABLE_DEPTH);
  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PPROD_W = PHASE_W + POS_W;
  localparam int M_W     = $clog2(RAMP_SAMPLES + 1);
  // Envelope = floor(m * 2^16 / RAMP) as m * ceil(2^42 / RAMP) >> 26, exact for m < 1024.
  localparam int ENV_SHIFT = 26;
  localparam int ER_W      = 16 + ENV_SHIFT + 1;
  localparam logic [ER_W-1:0] ENV_RECIP = ER_W'(((64'd1 << (16 + ENV_SHIFT)) +
    64'(RAMP_SAMPLES) - 64'd1) / 64'(RAMP_SAMPLES));
  localparam int EP_W = M_W + ER_W;
  // Sample count = floor(rate * dur / 1000), taken as floor((x >> 3) / 125) through
  // a multiply by ceil(2^36 / 125); exact for every 32-bit x.
  localparam int CNT_PRE   = 3;
  localparam int CNT_SHIFT = 36;
  localparam int CNT_RW    = 30;
  localparam int CNT_XW    = RATE_W + DUR_W - CNT_PRE;
  localparam int CNT_PW    = CNT_XW + CNT_RW;
  localparam int CNT_QW    = CNT_PW - CNT_SHIFT;
  localparam logic [63:0] CNT_DIV = 64'(MS_PER_S) >> CNT_PRE;
  localparam logic [CNT_RW-1:0] CNT_RECIP =
    CNT_RW'(((64'd1 << CNT_SHIFT) + CNT_DIV - 64'd1) / CNT_DIV);
  localparam logic [POS_W-1:0]  Q1_POS  = POS_W'(SINE_TABLE_DEPTH);
  localparam logic [POS_W-1:0]  Q2_POS  = POS_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [POS_W-1:0]  Q3_POS  = POS_W'(3 * SINE_TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] TOP_ADR = ADDR_W'(SINE_TABLE_DEPTH);
  localparam logic [TOTAL_W:0]  RAMP_X  = (TOTAL_W + 1)'(RAMP_SAMPLES);
  localparam logic [ENV_W-1:0]  ENV_ONE = ENV_W'(65536);
  localparam int MAG_SHIFT = 47;
  localparam int P2_W      = SINE_W + ENV_W + G30_W;
  localparam logic [SAMPLE_W-1:0] MAG_MAX = SAMPLE_W'(32767);

  // Configuration registers and derived gain.
  logic [RATE_W-1:0] rate;
  logic [VOL_W-1:0]  vol;
  logic [VOL_W-1:0]  vol_c;
  logic [GAIN_W-1:0] gain;
  logic [G30_W-1:0]  g30;
  logic [GAIN_RW+VOL_W-1:0] gain_prod;

  // Tone state.
  logic [TOTAL_W-1:0] idx;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] cnt_sat;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] inc;
  logic               active;

  // Start setup.
  logic [FREQ_W-1:0]          freq;
  logic [RATE_W+DUR_W-1:0]    rd_prod;
  logic [CNT_PW-1:0]          cnt_prod;
  logic [CNT_QW-1:0]          cnt_q;
  logic                       div_load;
  logic [DIV_DVD_W-1:0]       div_dvd;
  logic [RATE_W-1:0]          div_dsr;
  logic                       div_busy;
  logic [PHASE_W-1:0]         div_q;

  // Tick pipeline.
  logic [PPROD_W-1:0] pos_prod;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   k;
  logic [1:0]         quad;
  logic [ADDR_W-1:0]  rom_addr;
  logic [SINE_W-1:0]  sine_rom [0:SINE_TABLE_DEPTH];
  logic [SINE_W-1:0]  sine_q;
  logic               neg;
  logic               last;
  logic               attack;
  logic               release_ph;
  logic [TOTAL_W-1:0] rel_m;
  logic [M_W-1:0]     m;
  logic [EP_W-1:0]    env_prod;
  logic [ENV_W-1:0]   env;
  logic [SINE_W+ENV_W-1:0] p1;
  logic [P2_W-1:0]    p2;
  logic [SAMPLE_W-1:0] mag_raw;
  logic [SAMPLE_W-1:0] mag;

  assign vol_c     = (vol > VOL_MAX) ? VOL_MAX : vol;
  assign gain_prod = (GAIN_RW + VOL_W)'(vol_c) * (GAIN_RW + VOL_W)'(GAIN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
      vol  <= VOL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SAMPLE_RATE: rate <= cfg_data[RATE_W-1:0];
        CFG_VOLUME:      vol  <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    gain <= gain_prod[GAIN_SHIFT +: GAIN_W];
    g30  <= G30_W'(G30_W'(gain) * G30_W'(AMPLITUDE));
  end

  // The sample count saturates at the width of the counter.
  assign cnt_q   = cnt_prod[CNT_SHIFT +: CNT_QW];
  assign cnt_sat = (|cnt_q[CNT_QW-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : cnt_q[TOTAL_W-1:0];

  // The divider only works out the phase increment.
  assign div_load = cmd.inc_load;
  assign div_dvd  = {freq, {PHASE_W{1'b0}}};
  assign div_dsr  = rate;

  estg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      freq    <= in_freq;
      rd_prod <= (RATE_W + DUR_W)'(rate) * (RATE_W + DUR_W)'(in_dur);
    end
    if (cmd.cnt_load) begin
      cnt_prod <= CNT_PW'(rd_prod[RATE_W+DUR_W-1:CNT_PRE]) * CNT_PW'(CNT_RECIP);
    end
  end

  // Sine table, read one registered address per tick.
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] XK = (PI_HALF_Q30 * 64'(g)) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[g] = sine_from_x(XK);
  end

  assign pos_prod = PPROD_W'(phase) * PPROD_W'(4 * SINE_TABLE_DEPTH);

  always_comb begin
    if (pos >= Q3_POS) begin
      quad = 2'd3;
      k    = pos - Q3_POS;
    end else if (pos >= Q2_POS) begin
      quad = 2'd2;
      k    = pos - Q2_POS;
    end else if (pos >= Q1_POS) begin
      quad = 2'd1;
      k    = pos - Q1_POS;
    end else begin
      quad = 2'd0;
      k    = pos;
    end
    rom_addr = quad[0] ? TOP_ADR - ADDR_W'(k) : ADDR_W'(k);
  end

  // Envelope: attack, release or full scale.
  assign attack     = {1'b0, idx} < RAMP_X;
  assign release_ph = ({1'b0, idx} + RAMP_X) > {1'b0, total};
  assign rel_m      = total - idx;
  assign m          = attack ? M_W'(idx) : M_W'(rel_m);
  assign env_prod   = EP_W'(m) * EP_W'(ENV_RECIP);

  assign mag_raw = p2[MAG_SHIFT +: SAMPLE_W];
  assign mag     = (mag_raw > MAG_MAX) ? MAG_MAX : mag_raw;

  always_ff @(posedge clk) begin
    if (cmd.tick_phase) begin
      pos  <= pos_prod[PHASE_W +: POS_W];
      env  <= (attack || release_ph) ? env_prod[ENV_SHIFT +: ENV_W] : ENV_ONE;
      last <= ({1'b0, idx} + (TOTAL_W + 1)'(1)) >= {1'b0, total};
    end
    if (cmd.tick_rom) begin
      sine_q <= sine_rom[rom_addr];
      neg    <= quad[1];
    end
    if (cmd.tick_mul1) begin
      p1 <= (SINE_W + ENV_W)'(sine_q) * (SINE_W + ENV_W)'(env);
    end
    if (cmd.tick_mul2) begin
      p2 <= P2_W'(p1) * P2_W'(g30);
    end
    if (cmd.tick_out) begin
      out_sample <= neg ? -$signed(mag) : $signed(mag);
      out_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      total     <= '0;
      phase     <= '0;
      inc       <= '0;
    end else begin
      if (cmd.tick_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.cnt_store) begin
        total <= cnt_sat;
      end
      if (cmd.start_done) begin
        inc    <= (rate == '0) ? '0 : div_q;
        phase  <= '0;
        idx    <= '0;
        active <= (total != '0);
      end else if (cmd.tick_out) begin
        idx   <= idx + 1'b1;
        phase <= phase + inc;
        if (last) begin
          active <= 1'b0;
        end
      end
    end
  end

  assign sts.div_busy    = div_busy;
  assign sts.tone_active = active;
  assign sts.out_busy    = out_valid && !out_ready;

endmodule

@@ sv/enveloped_sine_tone_generator.sv @@
// Top level of the enveloped sine tone generator: controller, datapath and checks.
`timescale 1ns / 1ps
// A start item (cmd 0) sets up a tone of freq_hz lasting tone_ms at the
// configured sample rate; each following tick item (cmd 1) returns one signed
// 16-bit sample, shaped by a linear attack and release of RAMP_SAMPLES samples
// and scaled by volume_percent, and the final sample of the tone carries
// last_sample. Ticks while no tone plays are consumed and give no sample. A
// start passes from acceptance through CNT_LOAD, CNT_WAIT, INC_LOAD and INC_WAIT
// before the next item is accepted: the sample count comes from a registered
// reciprocal multiply, and the phase increment then goes through a bit-serial
// divider on its 48-bit dividend, loaded in INC_LOAD and stored in INC_WAIT. A
// tick passes through T_PHASE, T_ROM, T_MUL1, T_MUL2 and T_OUT, the states that
// hold the registered sine table read and the two chained multipliers, before
// the next item can be accepted; the sample then waits in the output register
// while the block already takes the next item, and a tick only stalls if its
// own sample would overwrite one not yet taken. Configuration writes are
// always accepted and must be made while no tone work is in flight.
module enveloped_sine_tone_generator import estg_pkg::*; #(
  parameter int RAMP_SAMPLES     = RAMP_SAMPLES_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  estg_req_if.sink   req,
  estg_smp_if.source smp,
  estg_cfg_if.sink   cfg
);

  estg_cmd_t ctl;
  estg_sts_t sts;

  // Configuration writes are always accepted.
  assign cfg.ready = 1'b1;

  // The controller owns the input handshake and sequences the datapath.
  estg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (ctl)
  );

  // The datapath holds the tone state and drives the output register.
  estg_dp #(
    .RAMP_SAMPLES     (RAMP_SAMPLES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl),
    .sts        (sts),
    .in_freq    (req.freq_hz),
    .in_dur     (req.tone_ms),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .out_ready  (smp.ready),
    .out_valid  (smp.valid),
    .out_sample (smp.sample),
    .out_last   (smp.last_sample)
  );

`ifndef SYNTHESIS
  // A new sample appears only right after the tick pipeline finished.
  a_out_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(smp.valid) |-> $past(ctl.tick_out))
    else $error("sample appeared without a finished tick");

  // A finished tick never overwrites a sample still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.tick_out |-> (!smp.valid || smp.ready))
    else $error("output sample overwritten");

  // No item is taken while the divider works on a start.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    sts.div_busy |-> !req.ready)
    else $error("item accepted during division");

  // The last sample of a tone leaves the tone idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.tick_out && u_dp.last) |=> !sts.tone_active)
    else $error("tone still active after last sample");
`endif

endmodule
